// File: sv/dcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_pkg
// shared types, codes and packet constants of the dcc cv programming sequencer
// ----------------------------------------------------------------------------
package dcs_pkg;

    localparam int MAX_RES = 5;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    typedef enum logic [2:0] {
        ACT_WRITE_BYTE  = 3'd0,
        ACT_VERIFY_BYTE = 3'd1,
        ACT_WRITE_BIT   = 3'd2,
        ACT_READ        = 3'd3,
        ACT_OPS_WRITE   = 3'd4,
        ACT_ACK         = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        OP_IDLE        = 3'd0,
        OP_WRITE_BYTE  = 3'd1,
        OP_VERIFY_BYTE = 3'd2,
        OP_WRITE_BIT   = 3'd3,
        OP_READ_BIT    = 3'd4,
        OP_READ_VERIFY = 3'd5
    } pend_t;

    localparam logic [1:0] ST_ACK        = 2'd0;
    localparam logic [1:0] ST_NO_ACK     = 2'd1;
    localparam logic [1:0] ST_WRONG_MODE = 2'd2;
    localparam logic [1:0] ST_BUSY       = 2'd3;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [9:0] CV_MASK       = 10'h3ff;
    localparam logic [7:0] B1_VERIFY_BIT = 8'h78;
    localparam logic [7:0] B3_VERIFY_BIT = 8'he0;
    localparam logic [7:0] B3_WRITE_BIT  = 8'hf0;
    localparam logic [7:0] B1_WRITE_BYTE = 8'h7c;
    localparam logic [7:0] B1_VERIFY     = 8'h74;
    localparam logic [7:0] B1_LONG_ADDR  = 8'hc0;
    localparam logic [7:0] B1_OPS_WRITE  = 8'hec;
    localparam logic [13:0] SHORT_ADDR_MAX = 14'd127;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [1:0] status;
    } res_t;

    typedef struct packed {
        logic                      load;
        logic [CNT_W-1:0]          count;
        res_t [MAX_RES-1:0]        entry;
    } batch_t;

    function automatic res_t res_pkt(input logic [7:0] data);
        res_t r;
        r.kind   = KIND_PACKET;
        r.data   = data;
        r.status = ST_ACK;
        return r;
    endfunction

    function automatic res_t res_rep(input logic [7:0] data, input logic [1:0] status);
        res_t r;
        r.kind   = KIND_REPORT;
        r.data   = data;
        r.status = status;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/dcs_seq_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_seq_core
// input register, sequencer state and the single-pass result batch logic
// ----------------------------------------------------------------------------
module dcs_seq_core
    import dcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  action,
    input  wire logic [10:0] cv_number,
    input  wire logic [7:0]  value,
    input  wire logic [2:0]  bit_position,
    input  wire logic        bit_value,
    input  wire logic [13:0] loco_address,
    input  wire logic        acknowledged,
    input  wire logic        load_ok,
    output batch_t           batch
);

    logic        svc_mode_reg;
    logic        in_valid_reg;
    logic [2:0]  action_reg;
    logic [10:0] cv_reg;
    logic [7:0]  value_reg;
    logic [2:0]  bitpos_reg;
    logic        bitval_reg;
    logic [13:0] addr_reg;
    logic        ack_reg;

    pend_t       pend_reg, pend_next;
    logic [9:0]  rcv_reg, rcv_next;
    logic [2:0]  ridx_reg, ridx_next;
    logic [7:0]  racc_reg, racc_next;
    logic        tz_reg, tz_next;

    logic        consume;
    logic        accept;
    logic [10:0] cv_m1;
    logic [9:0]  field;
    logic        is_service;
    logic [1:0]  ack_status;

    assign consume  = in_valid_reg && load_ok;
    assign in_stall = in_valid_reg && !load_ok;
    assign accept   = in_valid && !in_stall;
    assign cv_m1    = cv_reg - 11'd1;
    assign field    = cv_m1[9:0] & CV_MASK;
    assign is_service = (action_reg != ACT_OPS_WRITE);
    assign ack_status = ack_reg ? ST_ACK : ST_NO_ACK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            svc_mode_reg <= 1'b0;
            in_valid_reg <= 1'b0;
            pend_reg     <= OP_IDLE;
            rcv_reg      <= '0;
            ridx_reg     <= 3'd7;
            racc_reg     <= '0;
            tz_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                svc_mode_reg <= cfg_wr_data;
            if (accept)
                in_valid_reg <= 1'b1;
            else if (consume)
                in_valid_reg <= 1'b0;
            if (consume)
            begin
                pend_reg <= pend_next;
                rcv_reg  <= rcv_next;
                ridx_reg <= ridx_next;
                racc_reg <= racc_next;
                tz_reg   <= tz_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            cv_reg     <= cv_number;
            value_reg  <= value;
            bitpos_reg <= bit_position;
            bitval_reg <= bit_value;
            addr_reg   <= loco_address;
            ack_reg    <= acknowledged;
        end
    end

    always_comb
    begin
        logic [7:0] acc;
        logic [2:0] idx;
        acc       = racc_reg;
        idx       = ridx_reg;
        pend_next = pend_reg;
        rcv_next  = rcv_reg;
        ridx_next = ridx_reg;
        racc_next = racc_reg;
        tz_next   = tz_reg;
        batch.count = '0;
        for (int i = 0; i < MAX_RES; i++)
            batch.entry[i] = res_pkt(8'd0);

        case (action_reg)
            ACT_ACK:
            begin
                case (pend_reg)
                    OP_WRITE_BYTE, OP_VERIFY_BYTE, OP_WRITE_BIT:
                    begin
                        batch.entry[0] = res_rep(8'd0, ack_status);
                        batch.count    = CNT_W'(1);
                        pend_next      = OP_IDLE;
                    end
                    OP_READ_BIT:
                    begin
                        if (!tz_reg && !ack_reg)
                        begin
                            // bit 1 refused, try bit 0
                            tz_next = 1'b1;
                            batch.entry[0] = res_pkt(B1_VERIFY_BIT | {6'd0, rcv_reg[9:8]});
                            batch.entry[1] = res_pkt(rcv_reg[7:0]);
                            batch.entry[2] = res_pkt(B3_VERIFY_BIT | {5'd0, ridx_reg});
                            batch.count    = CNT_W'(3);
                        end
                        else if (tz_reg && !ack_reg)
                        begin
                            // neither value acknowledged, read ends early
                            tz_next   = 1'b0;
                            acc       = racc_reg >> ridx_reg;
                            racc_next = acc;
                            batch.entry[0] = res_rep(acc, ST_NO_ACK);
                            batch.entry[1] = res_pkt(B1_VERIFY | {6'd0, rcv_reg[9:8]});
                            batch.entry[2] = res_pkt(rcv_reg[7:0]);
                            batch.entry[3] = res_pkt(acc);
                            batch.count    = CNT_W'(4);
                            pend_next      = OP_READ_VERIFY;
                        end
                        else
                        begin
                            tz_next = 1'b0;
                            if (!tz_reg)
                                acc = racc_reg | 8'(8'd1 << ridx_reg);
                            racc_next = acc;
                            if (ridx_reg == 3'd0)
                            begin
                                batch.entry[0] = res_rep(acc, ST_ACK);
                                batch.entry[1] = res_pkt(B1_VERIFY | {6'd0, rcv_reg[9:8]});
                                batch.entry[2] = res_pkt(rcv_reg[7:0]);
                                batch.entry[3] = res_pkt(acc);
                                batch.count    = CNT_W'(4);
                                pend_next      = OP_READ_VERIFY;
                            end
                            else
                            begin
                                idx       = ridx_reg - 3'd1;
                                ridx_next = idx;
                                batch.entry[0] = res_pkt(B1_VERIFY_BIT | {6'd0, rcv_reg[9:8]});
                                batch.entry[1] = res_pkt(rcv_reg[7:0]);
                                batch.entry[2] = res_pkt(B3_VERIFY_BIT | 8'h08 | {5'd0, idx});
                                batch.count    = CNT_W'(3);
                            end
                        end
                    end
                    OP_READ_VERIFY:
                    begin
                        batch.entry[0] = res_rep(racc_reg, ack_status);
                        batch.count    = CNT_W'(1);
                        pend_next      = OP_IDLE;
                        ridx_next      = 3'd7;
                    end
                    default:
                    begin
                        pend_next = OP_IDLE;
                    end
                endcase
            end
            ACT_WRITE_BYTE, ACT_VERIFY_BYTE, ACT_WRITE_BIT, ACT_READ, ACT_OPS_WRITE:
            begin
                if (pend_reg != OP_IDLE)
                begin
                    batch.entry[0] = res_rep(8'd0, ST_BUSY);
                    batch.count    = CNT_W'(1);
                end
                else if (is_service != svc_mode_reg)
                begin
                    batch.entry[0] = res_rep(8'd0, ST_WRONG_MODE);
                    batch.count    = CNT_W'(1);
                end
                else if (action_reg == ACT_OPS_WRITE)
                begin
                    if (addr_reg > SHORT_ADDR_MAX)
                    begin
                        batch.entry[0] = res_pkt(B1_LONG_ADDR | {2'd0, addr_reg[13:8]});
                        batch.entry[1] = res_pkt(addr_reg[7:0]);
                        batch.entry[2] = res_pkt(B1_OPS_WRITE | {6'd0, field[9:8]});
                        batch.entry[3] = res_pkt(field[7:0]);
                        batch.entry[4] = res_pkt(value_reg);
                        batch.count    = CNT_W'(5);
                    end
                    else
                    begin
                        batch.entry[0] = res_pkt(addr_reg[7:0]);
                        batch.entry[1] = res_pkt(B1_OPS_WRITE | {6'd0, field[9:8]});
                        batch.entry[2] = res_pkt(field[7:0]);
                        batch.entry[3] = res_pkt(value_reg);
                        batch.count    = CNT_W'(4);
                    end
                end
                else
                begin
                    batch.entry[1] = res_pkt(field[7:0]);
                    batch.count    = CNT_W'(3);
                    case (action_reg)
                        ACT_WRITE_BYTE:
                        begin
                            batch.entry[0] = res_pkt(B1_WRITE_BYTE | {6'd0, field[9:8]});
                            batch.entry[2] = res_pkt(value_reg);
                            pend_next      = OP_WRITE_BYTE;
                        end
                        ACT_VERIFY_BYTE:
                        begin
                            batch.entry[0] = res_pkt(B1_VERIFY | {6'd0, field[9:8]});
                            batch.entry[2] = res_pkt(value_reg);
                            pend_next      = OP_VERIFY_BYTE;
                        end
                        ACT_WRITE_BIT:
                        begin
                            batch.entry[0] = res_pkt(B1_VERIFY_BIT | {6'd0, field[9:8]});
                            batch.entry[2] = res_pkt(B3_WRITE_BIT | {4'd0, bitval_reg, bitpos_reg});
                            pend_next      = OP_WRITE_BIT;
                        end
                        default:
                        begin
                            // bitwise read starts with verify bit 7 is 1
                            rcv_next       = field;
                            ridx_next      = 3'd7;
                            racc_next      = 8'd0;
                            tz_next        = 1'b0;
                            batch.entry[0] = res_pkt(B1_VERIFY_BIT | {6'd0, field[9:8]});
                            batch.entry[2] = res_pkt(B3_VERIFY_BIT | 8'h08 | 8'd7);
                            pend_next      = OP_READ_BIT;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        batch.load = consume && (batch.count != '0);
    end

endmodule
`default_nettype wire

// File: sv/dcs_result_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_result_buffer
// result register holding one batch, shifted out one item per cycle while out_stall is low
// ----------------------------------------------------------------------------
module dcs_result_buffer
    import dcs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire batch_t batch,
    output logic        load_ok,
    output logic        out_valid,
    input  wire logic   out_stall,
    output logic        result_kind,
    output logic [7:0]  data_byte,
    output logic [1:0]  status,
    output logic        last_in_run
);

    res_t [MAX_RES-1:0] entry_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic               take;

    assign out_valid   = (rem_reg != '0);
    assign take        = out_valid && !out_stall;
    assign load_ok     = (rem_reg == '0) || (take && rem_reg == CNT_W'(1));
    assign result_kind = entry_reg[0].kind;
    assign data_byte   = entry_reg[0].data;
    assign status      = entry_reg[0].status;
    assign last_in_run = (rem_reg == CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else if (batch.load)
            rem_reg <= batch.count;
        else if (take)
            rem_reg <= rem_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (batch.load)
            entry_reg <= batch.entry;
        else if (take)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
                entry_reg[i] <= entry_reg[i+1];
        end
    end

endmodule
`default_nettype wire

// File: sv/dcc_cv_programming_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcc_cv_programming_sequencer
// dcc service and operations mode cv programming packet sequencer
// path: first result of an item is offered from the result register, which is
//   loaded from the input register through the batch logic
// throughput: one item per cycle, or one per result when an item gives several
//   (up to five), set by the one-batch result register, while out_stall is low
// reset: idle, nothing awaited, service mode off; results pending are dropped
// ----------------------------------------------------------------------------
module dcc_cv_programming_sequencer
    import dcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  action,
    input  wire logic [10:0] cv_number,
    input  wire logic [7:0]  value,
    input  wire logic [2:0]  bit_position,
    input  wire logic        bit_value,
    input  wire logic [13:0] loco_address,
    input  wire logic        acknowledged,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             result_kind,
    output logic [7:0]       data_byte,
    output logic [1:0]       status,
    output logic             last_in_run
);

    batch_t batch;
    logic   load_ok;

    dcs_seq_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .cv_number    (cv_number),
        .value        (value),
        .bit_position (bit_position),
        .bit_value    (bit_value),
        .loco_address (loco_address),
        .acknowledged (acknowledged),
        .load_ok      (load_ok),
        .batch        (batch)
    );

    dcs_result_buffer u_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch       (batch),
        .load_ok     (load_ok),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .data_byte   (data_byte),
        .status      (status),
        .last_in_run (last_in_run)
    );

endmodule
`default_nettype wire
